// ===== rtl/expression_syntax_checker_macros.svh =====
// ---------------------------------------------------------------------------
// Expression syntax checker assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ---------------------------------------------------------------------------
`ifndef EXPRESSION_SYNTAX_CHECKER_MACROS_SVH
`define EXPRESSION_SYNTAX_CHECKER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/esc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Expression syntax checker package
// Sizes, character codes, item classes, status codes and the queue structs.
// ---------------------------------------------------------------------------
package esc_pkg;

  // Stack and counter sizes.
  localparam int MAX_DEPTH   = 16;
  localparam int COUNT_BITS  = 12;
  localparam int PTR_BITS    = $clog2(MAX_DEPTH);

  // Queue between the classifier and the checker.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  // Character codes.
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_OPEN  = 8'h28;
  localparam logic [7:0] CHR_CLOSE = 8'h29;

  // Class of one input item, as decided by the classifier.
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_DOT   = 3'd2,
    CLS_OP    = 3'd3,
    CLS_OPEN  = 3'd4,
    CLS_CLOSE = 3'd5,
    CLS_EOL   = 3'd6
  } char_class_t;

  // Line status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DOTS     = 3'd1,
    ST_OPERAND  = 3'd2,
    ST_NESTED   = 3'd3,
    ST_COUNT    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Write side of the queue.
  typedef struct packed {
    logic        valid;
    char_class_t cls;
  } q_push_t;

  // Head of the queue as seen by the checker.
  typedef struct packed {
    logic        valid;
    char_class_t cls;
  } q_head_t;

endpackage

// ===== rtl/expression_syntax_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Expression syntax checker
// Checks arithmetic expression syntax one character per item and reports a
// status and a bracket-balance flag at each line end.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_character[7:0]
//   out_     output     out_valid / out_stall out_syntax_status[2:0],
//                                             out_brackets_balanced
//
// One item per cycle is sustained while no line-end item waits on a stalled
// result. A line-end item passes the class queue, then the checker's state
// update, which loads the result register.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A stalled result holds only line-end items back; the four-entry queue
// keeps taking input until it fills.
// ---------------------------------------------------------------------------
module expression_syntax_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_syntax_status,
  output logic       out_brackets_balanced
);
  import esc_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  // Classifier.
  esc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .q_full       (q_full),
    .push         (push)
  );

  // Queue of classified items.
  esc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // Checker and result register.
  esc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_syntax_status     (out_syntax_status),
    .out_brackets_balanced (out_brackets_balanced)
  );

endmodule

// ===== rtl/esc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Expression syntax checker front end
// Accepts input characters and sorts each into a class for the checker.
// ---------------------------------------------------------------------------
module esc_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_character,
  input  logic              q_full,
  output esc_pkg::q_push_t  push
);
  import esc_pkg::*;

  char_class_t cls;

  // Sort the character into the class that drives the checker.
  always_comb begin
    cls = CLS_OTHER;
    if (in_character == CHR_LF || in_character == CHR_NUL) begin
      cls = CLS_EOL;
    end else if (in_character >= CHR_ZERO && in_character <= CHR_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_character == CHR_DOT) begin
      cls = CLS_DOT;
    end else if (in_character == CHR_PLUS || in_character == CHR_MINUS ||
                 in_character == CHR_STAR || in_character == CHR_SLASH) begin
      cls = CLS_OP;
    end else if (in_character == CHR_OPEN) begin
      cls = CLS_OPEN;
    end else if (in_character == CHR_CLOSE) begin
      cls = CLS_CLOSE;
    end
  end

  // The input stalls only while the queue is full.
  assign in_stall   = q_full;
  assign push.valid = in_valid && !q_full;
  assign push.cls   = cls;

endmodule

// ===== rtl/esc_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Expression syntax checker class queue
// Short FIFO of classified items between the front end and the checker.
// ---------------------------------------------------------------------------
module esc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  esc_pkg::q_push_t  push,
  output logic              full,
  output esc_pkg::q_head_t  head,
  input  logic              pop
);
  import esc_pkg::*;

  char_class_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   count_r, count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cls   = slot_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cls;
    end
  end

endmodule

// ===== rtl/esc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Expression syntax checker back end
// Runs the per-level operand counts and bracket balance, and emits the status.
// ---------------------------------------------------------------------------
`include "expression_syntax_checker_macros.svh"

module esc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  esc_pkg::q_head_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_syntax_status,
  output logic              out_brackets_balanced
);
  import esc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [COUNT_BITS-1:0] BAL_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] BAL_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [PTR_BITS-1:0] PTR_TOP = PTR_BITS'(MAX_DEPTH - 1);

  // Saved counts of the outer levels; the current level lives in cur_r.
  logic [COUNT_BITS-1:0]        stack_r [MAX_DEPTH];
  logic                         stk_we;
  logic [COUNT_BITS-1:0]        stk_wdata;

  logic [COUNT_BITS-1:0]        cur_r, cur_nxt;
  logic [PTR_BITS-1:0]          ptr_r, ptr_nxt;
  logic                         in_number_r, in_number_nxt;
  logic [1:0]                   dots_r, dots_nxt;
  logic                         latched_r, latched_nxt;
  status_t                      lstatus_r, lstatus_nxt;
  logic signed [COUNT_BITS-1:0] bal_r, bal_nxt;

  logic                         out_valid_r, out_valid_nxt;
  status_t                      out_status_r, out_status_nxt;
  logic                         out_bal_r, out_bal_nxt;

  logic                         out_free;
  logic                         fire;
  logic                         eol_fire;
  logic [1:0]                   dots_inc;
  status_t                      nest_code;

  // An end of line needs a free output slot; other items never wait.
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = head.valid && (head.cls != CLS_EOL || out_free);
  assign eol_fire = fire && (head.cls == CLS_EOL);
  assign pop      = fire;
  assign dots_inc = dots_r + 1'b1;

  // Dot and operand errors found inside brackets report as a nested error.
  always_comb begin
    nest_code = ST_NESTED;
    if (ptr_r == '0) begin
      nest_code = ST_OPERAND;
      if (head.cls == CLS_DOT) begin
        nest_code = ST_DOTS;
      end
    end
  end

  // Checker state update for one item.
  always_comb begin
    cur_nxt       = cur_r;
    ptr_nxt       = ptr_r;
    in_number_nxt = in_number_r;
    dots_nxt      = dots_r;
    latched_nxt   = latched_r;
    lstatus_nxt   = lstatus_r;
    bal_nxt       = bal_r;
    stk_we        = 1'b0;
    stk_wdata     = cur_r + 1'b1;

    if (eol_fire) begin
      cur_nxt       = '0;
      ptr_nxt       = '0;
      in_number_nxt = 1'b0;
      dots_nxt      = '0;
      latched_nxt   = 1'b0;
      lstatus_nxt   = ST_OK;
      bal_nxt       = '0;
    end else if (fire) begin
      // Bracket balance runs for the whole line and sticks at its limits.
      if (bal_r != BAL_MAX && bal_r != BAL_MIN) begin
        if (head.cls == CLS_OPEN && !bal_r[COUNT_BITS-1]) begin
          bal_nxt = bal_r + 1'b1;
        end else if (head.cls == CLS_CLOSE) begin
          bal_nxt = bal_r - 1'b1;
        end
      end

      if (!latched_r) begin
        case (head.cls)
          CLS_DIGIT: begin
            if (!in_number_r) begin
              in_number_nxt = 1'b1;
              dots_nxt      = '0;
              if (cur_r == CNT_MAX) begin
                latched_nxt = 1'b1;
                lstatus_nxt = ST_OVERFLOW;
              end else begin
                cur_nxt = cur_r + 1'b1;
              end
            end
          end
          CLS_DOT: begin
            if (in_number_r) begin
              dots_nxt = dots_inc;
              if (dots_inc > 2'd1) begin
                latched_nxt = 1'b1;
                lstatus_nxt = nest_code;
              end
            end
          end
          CLS_OP: begin
            in_number_nxt = 1'b0;
            dots_nxt      = '0;
            if (cur_r == '0) begin
              latched_nxt = 1'b1;
              lstatus_nxt = nest_code;
            end else begin
              cur_nxt = cur_r - 1'b1;
            end
          end
          CLS_OPEN: begin
            in_number_nxt = 1'b0;
            dots_nxt      = '0;
            if (cur_r == CNT_MAX) begin
              latched_nxt = 1'b1;
              lstatus_nxt = ST_OVERFLOW;
            end else if (ptr_r == PTR_TOP) begin
              cur_nxt     = cur_r + 1'b1;
              latched_nxt = 1'b1;
              lstatus_nxt = ST_OVERFLOW;
            end else begin
              // Save the bracket as an operand of this level, open a new one.
              stk_we  = 1'b1;
              ptr_nxt = ptr_r + 1'b1;
              cur_nxt = '0;
            end
          end
          CLS_CLOSE: begin
            in_number_nxt = 1'b0;
            dots_nxt      = '0;
            if (ptr_r == '0) begin
              // A stray closing bracket at the top accepts the line early.
              latched_nxt = 1'b1;
              lstatus_nxt = ST_OK;
            end else begin
              ptr_nxt = ptr_r - 1'b1;
              cur_nxt = stack_r[ptr_r - 1'b1];
            end
          end
          default: begin
            in_number_nxt = 1'b0;
            dots_nxt      = '0;
          end
        endcase
      end
    end
  end

  // Result of a finished line.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_bal_nxt    = out_bal_r;
    if (eol_fire) begin
      out_valid_nxt = 1'b1;
      out_bal_nxt   = (bal_r == '0);
      if (latched_r) begin
        out_status_nxt = lstatus_r;
      end else if (ptr_r != '0) begin
        out_status_nxt = ST_NESTED;
      end else if (cur_r != COUNT_BITS'(1)) begin
        out_status_nxt = ST_COUNT;
      end else begin
        out_status_nxt = ST_OK;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      ptr_r       <= '0;
      in_number_r <= 1'b0;
      dots_r      <= '0;
      latched_r   <= 1'b0;
      lstatus_r   <= ST_OK;
      bal_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      ptr_r       <= ptr_nxt;
      in_number_r <= in_number_nxt;
      dots_r      <= dots_nxt;
      latched_r   <= latched_nxt;
      lstatus_r   <= lstatus_nxt;
      bal_r       <= bal_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_bal_r    <= out_bal_nxt;
  end

  // Saved level counts.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_r[ptr_r] <= stk_wdata;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_syntax_status     = out_status_r;
  assign out_brackets_balanced = out_bal_r;

  // A finished line leaves the checker at the top level with nothing latched.
  `ESC_ASSERT_NEXT(a_eol_clears, clk, rst_n, eol_fire, (ptr_r == '0) && !latched_r && (cur_r == '0) && (bal_r == '0), "line end did not clear the checker")
  // A latched verdict holds until the line ends.
  `ESC_ASSERT_NEXT(a_latch_holds, clk, rst_n, latched_r && !eol_fire, latched_r && $stable(lstatus_r), "latched verdict changed within a line")
  // The bracket balance sticks once it reaches its upper limit.
  `ESC_ASSERT_NEXT(a_bal_sticks, clk, rst_n, (bal_r == BAL_MAX) && !eol_fire, bal_r == BAL_MAX, "bracket balance left its upper limit")
  // Until a verdict is latched, the balance never goes negative while the stack is deeper than the top.
  `ESC_ASSERT_NOW(a_bal_vs_ptr, clk, rst_n, !latched_r && (ptr_r != '0), !bal_r[COUNT_BITS-1], "open level with negative bracket balance")

endmodule
